FILE: rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// shared types, codes and constants of the page bitmap allocator
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int DEF_PAGE_COUNT = 1024;
	localparam int DEF_PAGE_SIZE  = 16384;

	localparam int           BITS_PER_BYTE = 8;
	localparam logic [7:0]   BYTE_FULL     = 8'hFF;

	// request kinds
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_MARK  = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] page_address;
		logic [9:0]  page_number;
		logic        mark_used;
	} pba_req_t;

	typedef struct packed {
		logic [31:0] granted_address;
		logic [1:0]  status;
	} pba_rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_GRANT_MUL,
		S_GRANT_ADD,
		S_FREE_MUL,
		S_FREE_QD,
		S_FREE_PROD,
		S_FREE_FIX,
		S_FREE_CHK,
		S_PAGE_RD,
		S_PAGE_WR,
		S_DONE
	} pba_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic clr;
		logic load;
		logic scan_rd;
		logic scan_chk;
		logic grant_mul;
		logic grant_add;
		logic free_mul;
		logic free_qd;
		logic free_prod;
		logic free_fix;
		logic free_chk;
		logic page_rd;
		logic page_wr;
	} pba_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic       clr_last;
		logic [1:0] kind;
		logic       req_bad;
		logic       byte_full;
		logic       scan_last;
		logic       cand_ok;
		logic       free_bad;
	} pba_stat_t;

endpackage

FILE: rtl/page_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator_top
// first-fit physical page allocator over a used/free bitmap
// ----------------------------------------------------------------------------
// after reset the block runs a clearing pass over the bitmap ram, one byte a
// cycle, with busy high. a command is taken when start is high and busy is
// low; the single result appears later on rsp for exactly one cycle with done
// high, and the receiver must take it then, there is no back-pressure. a mark
// by index is a read-modify-write of one byte; a free by address runs a
// reciprocal multiply, a correction, then a read-modify-write of one byte; an
// allocate reads the bitmap one ram read per byte, starting at a hint below
// which every byte is known full. requests that end early: allocate with no
// free page, free outside the managed range, out-of-range mark and the unused
// kind. memory_base is written through the cfg channel, which is always
// ready; write it only while the block is idle.
module page_bitmap_allocator_top #(
	parameter int PAGE_COUNT = pba_pkg::DEF_PAGE_COUNT,
	parameter int PAGE_SIZE  = pba_pkg::DEF_PAGE_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  pba_pkg::pba_req_t req,
	// result channel
	output logic              done,
	output pba_pkg::pba_rsp_t rsp,
	// memory_base write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data
);

	pba_pkg::pba_cmd_t  cmd;
	pba_pkg::pba_stat_t stat;

	// base register is a plain register, always writable
	assign cfg_ready = 1'b1;

	pba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pba_dp #(
		.PAGE_COUNT (PAGE_COUNT),
		.PAGE_SIZE  (PAGE_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.stat     (stat),
		.rsp      (rsp)
	);

endmodule

FILE: rtl/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/pba_ctrl.sv
// ----------------------------------------------------------------------------
// pba_ctrl
// sequencing state machine of the page bitmap allocator
// ----------------------------------------------------------------------------
module pba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pba_pkg::pba_stat_t  stat,
	output pba_pkg::pba_cmd_t   cmd,
	output logic                busy,
	output logic                done
);

	pba_pkg::pba_state_t state_q;
	pba_pkg::pba_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pba_pkg::S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pba_pkg::S_CLEAR: begin
				if (stat.clr_last) state_nxt = pba_pkg::S_IDLE;
			end
			pba_pkg::S_IDLE: begin
				if (start) state_nxt = pba_pkg::S_DISPATCH;
			end
			pba_pkg::S_DISPATCH: begin
				unique case (stat.kind)
					pba_pkg::KIND_ALLOC: state_nxt = pba_pkg::S_SCAN_RD;
					pba_pkg::KIND_FREE:  state_nxt = pba_pkg::S_FREE_MUL;
					pba_pkg::KIND_MARK: begin
						state_nxt = stat.req_bad ? pba_pkg::S_DONE : pba_pkg::S_PAGE_RD;
					end
					default:             state_nxt = pba_pkg::S_DONE;
				endcase
			end
			pba_pkg::S_SCAN_RD:   state_nxt = pba_pkg::S_SCAN_CHK;
			pba_pkg::S_SCAN_CHK: begin
				if (stat.byte_full && !stat.scan_last) begin
					state_nxt = pba_pkg::S_SCAN_RD;
				end else if (stat.byte_full || !stat.cand_ok) begin
					state_nxt = pba_pkg::S_DONE;
				end else begin
					state_nxt = pba_pkg::S_GRANT_MUL;
				end
			end
			pba_pkg::S_GRANT_MUL: state_nxt = pba_pkg::S_GRANT_ADD;
			pba_pkg::S_GRANT_ADD: state_nxt = pba_pkg::S_DONE;
			pba_pkg::S_FREE_MUL:  state_nxt = pba_pkg::S_FREE_QD;
			pba_pkg::S_FREE_QD:   state_nxt = pba_pkg::S_FREE_PROD;
			pba_pkg::S_FREE_PROD: state_nxt = pba_pkg::S_FREE_FIX;
			pba_pkg::S_FREE_FIX:  state_nxt = pba_pkg::S_FREE_CHK;
			pba_pkg::S_FREE_CHK: begin
				state_nxt = stat.free_bad ? pba_pkg::S_DONE : pba_pkg::S_PAGE_RD;
			end
			pba_pkg::S_PAGE_RD:   state_nxt = pba_pkg::S_PAGE_WR;
			pba_pkg::S_PAGE_WR:   state_nxt = pba_pkg::S_DONE;
			pba_pkg::S_DONE:      state_nxt = pba_pkg::S_IDLE;
			default:              state_nxt = pba_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			pba_pkg::S_CLEAR:     cmd.clr = 1'b1;
			pba_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			pba_pkg::S_DISPATCH:  ;
			pba_pkg::S_SCAN_RD:   cmd.scan_rd   = 1'b1;
			pba_pkg::S_SCAN_CHK:  cmd.scan_chk  = 1'b1;
			pba_pkg::S_GRANT_MUL: cmd.grant_mul = 1'b1;
			pba_pkg::S_GRANT_ADD: cmd.grant_add = 1'b1;
			pba_pkg::S_FREE_MUL:  cmd.free_mul  = 1'b1;
			pba_pkg::S_FREE_QD:   cmd.free_qd   = 1'b1;
			pba_pkg::S_FREE_PROD: cmd.free_prod = 1'b1;
			pba_pkg::S_FREE_FIX:  cmd.free_fix  = 1'b1;
			pba_pkg::S_FREE_CHK:  cmd.free_chk  = 1'b1;
			pba_pkg::S_PAGE_RD:   cmd.page_rd   = 1'b1;
			pba_pkg::S_PAGE_WR:   cmd.page_wr   = 1'b1;
			pba_pkg::S_DONE:      done = 1'b1;
			default:              ;
		endcase
	end

endmodule

FILE: rtl/pba_dp.sv
// ----------------------------------------------------------------------------
// pba_dp
// datapath: bitmap ram, scan pointer, free hint, address arithmetic
// ----------------------------------------------------------------------------
module pba_dp #(
	parameter int PAGE_COUNT = pba_pkg::DEF_PAGE_COUNT,
	parameter int PAGE_SIZE  = pba_pkg::DEF_PAGE_SIZE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pba_pkg::pba_cmd_t  cmd,
	input  pba_pkg::pba_req_t  req,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_data,
	output pba_pkg::pba_stat_t stat,
	output pba_pkg::pba_rsp_t  rsp
);

	localparam int MAP_BYTES = (PAGE_COUNT + pba_pkg::BITS_PER_BYTE - 1) / pba_pkg::BITS_PER_BYTE;
	localparam int BW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int PW        = BW + 3;

	localparam logic [63:0] RECIP_W  = (64'd1 << 32) / 64'(PAGE_SIZE);
	localparam logic [31:0] RECIP    = RECIP_W[31:0];
	localparam logic [31:0] PSIZE    = 32'(PAGE_SIZE);
	localparam logic [31:0] PCOUNT   = 32'(PAGE_COUNT);
	localparam logic [BW-1:0] LAST_B = BW'(MAP_BYTES - 1);

	// control registers
	logic [BW-1:0] clr_q;
	logic [BW-1:0] hint_q;
	logic [31:0]   base_q;

	// per item registers
	logic [1:0]    kind_q;
	logic [1:0]    status_q;
	logic [31:0]   grant_q;
	logic          wr_val_q;
	logic [BW-1:0] scan_q;
	logic [PW-1:0] page_q;
	logic [31:0]   off_q;
	logic          below_q;
	logic [63:0]   mprod_q;
	logic [31:0]   quo_q;
	logic [31:0]   qd_q;
	logic [31:0]   gprod_q;

	// ram ports
	logic          ram_we;
	logic [BW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [BW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic [2:0]    free_bit;
	logic [PW-1:0] cand;
	logic          byte_full;
	logic          cand_ok;
	logic          scan_last;
	logic          take;
	logic [BW-1:0] page_byte;
	logic [7:0]    page_mask;
	logic [31:0]   rem;
	logic          mark_oor;

	assign page_byte = page_q[PW-1:3];
	assign page_mask = 8'(1) << page_q[2:0];

	// lowest clear bit of the byte just read
	always_comb begin
		free_bit = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!ram_rdata[i]) free_bit = 3'(i);
		end
	end

	assign byte_full = (ram_rdata == pba_pkg::BYTE_FULL);
	assign cand      = {scan_q, free_bit};
	assign cand_ok   = (32'(cand) < PCOUNT);
	assign scan_last = (scan_q == LAST_B);
	assign take      = cmd.scan_chk && !byte_full && cand_ok;
	assign rem       = off_q - qd_q;
	assign mark_oor  = (32'(req.page_number) >= PCOUNT);

	// ram port muxing
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 8'd0;
		if (cmd.clr) begin
			ram_we = 1'b1;
		end else if (take) begin
			ram_we    = 1'b1;
			ram_waddr = scan_q;
			ram_wdata = ram_rdata | (8'(1) << free_bit);
		end else if (cmd.page_wr) begin
			ram_we    = 1'b1;
			ram_waddr = page_byte;
			ram_wdata = wr_val_q ? (ram_rdata | page_mask) : (ram_rdata & ~page_mask);
		end
	end

	assign ram_re    = cmd.scan_rd || cmd.page_rd;
	assign ram_raddr = cmd.page_rd ? page_byte : scan_q;

	pba_ram #(
		.WIDTH (8),
		.DEPTH (MAP_BYTES),
		.AW    (BW)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// clear counter, free hint, base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			hint_q <= '0;
			base_q <= '0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + BW'(1);
			if (cfg_we) base_q <= cfg_data;
			// every byte below the hint is full
			if (take) hint_q <= scan_q;
			if (cmd.page_wr && !wr_val_q && (page_byte < hint_q)) hint_q <= page_byte;
		end
	end

	// per item datapath
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= req.kind;
			grant_q  <= '0;
			scan_q   <= hint_q;
			page_q   <= PW'(req.page_number);
			wr_val_q <= (req.kind == pba_pkg::KIND_MARK) && req.mark_used;
			off_q    <= req.page_address - base_q;
			below_q  <= (req.page_address < base_q);
			if ((req.kind == pba_pkg::KIND_ALLOC) || (req.kind == pba_pkg::KIND_FREE)) begin
				status_q <= pba_pkg::STAT_OK;
			end else if ((req.kind == pba_pkg::KIND_MARK) && !mark_oor) begin
				status_q <= pba_pkg::STAT_OK;
			end else begin
				status_q <= pba_pkg::STAT_RANGE;
			end
		end
		if (cmd.scan_chk) begin
			if (byte_full && !scan_last) begin
				scan_q <= scan_q + BW'(1);
			end else if (byte_full || !cand_ok) begin
				status_q <= pba_pkg::STAT_FULL;
			end else begin
				page_q <= cand;
			end
		end
		if (cmd.grant_mul) gprod_q <= 32'(page_q) * PSIZE;
		if (cmd.grant_add) grant_q <= base_q + gprod_q;
		// offset / page size by reciprocal, then one correction step
		if (cmd.free_mul)  mprod_q <= {32'd0, off_q} * {32'd0, RECIP};
		if (cmd.free_qd)   quo_q   <= mprod_q[63:32];
		if (cmd.free_prod) qd_q    <= quo_q * PSIZE;
		if (cmd.free_fix && (rem >= PSIZE)) quo_q <= quo_q + 32'd1;
		if (cmd.free_chk) begin
			if (stat.free_bad) begin
				status_q <= pba_pkg::STAT_RANGE;
			end else begin
				page_q <= quo_q[PW-1:0];
			end
		end
	end

	assign stat.clr_last  = (clr_q == LAST_B);
	assign stat.kind      = kind_q;
	assign stat.req_bad   = (status_q == pba_pkg::STAT_RANGE);
	assign stat.byte_full = byte_full;
	assign stat.scan_last = scan_last;
	assign stat.cand_ok   = cand_ok;
	assign stat.free_bad  = below_q || (quo_q >= PCOUNT);

	assign rsp.granted_address = grant_q;
	assign rsp.status          = status_q;

endmodule
